### sv/gsrf_pkg.sv
// Package for the group spacing row filter: command type passed from the
// front to the back, queue sizing, register map and back-end state codes.
// No dependencies.
package gsrf_pkg;

   localparam int GROUP_DEPTH_DEF = 64;

   // command queue between the front and the back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map
   localparam int          CSR_ADDR_W      = 2;
   localparam logic [1:0]  CSR_ADDR_MIN_GAP = 2'd0;
   localparam logic [15:0] MIN_GAP_RESET   = 16'd1;

   // flush: close the open group; store: write row into the group buffer
   typedef struct packed {
      logic        flush;
      logic        ovf;
      logic        store;
      logic [31:0] row;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_DRAIN
   } back_state_type;

endpackage

### sv/gsrf_front.sv
// Front of the group spacing row filter: group detection and spacing test.
// Turns accepted items into flush/store commands. Uses gsrf_pkg.
module gsrf_front #(
   parameter int GROUP_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                is_end,
   input  logic [31:0]         cluster_id,
   input  logic [31:0]         func_id,
   input  logic [31:0]         position,
   input  logic [31:0]         row_id,
   input  logic [15:0]         min_gap,
   output logic                cmd_push,
   output gsrf_pkg::cmd_type   cmd_data
);
   import gsrf_pkg::*;

   localparam int CNT_W = $clog2(GROUP_DEPTH + 1);

   logic             in_group_ff, in_group_in;
   logic [31:0]      cluster_ff, cluster_in;
   logic [31:0]      function_ff, function_in;
   logic [31:0]      last_pos_ff, last_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   logic             new_group;
   logic             spaced;

   assign new_group = !in_group_ff || (cluster_id != cluster_ff) ||
                      (func_id != function_ff);
   // 33-bit compare so the sum never wraps
   assign spaced = {1'b0, position} >= ({1'b0, last_pos_ff} + {17'd0, min_gap});

   always_comb begin
      in_group_in    = in_group_ff;
      cluster_in     = cluster_ff;
      function_in    = function_ff;
      last_pos_in    = last_pos_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      cmd_data.flush = 1'b0;
      cmd_data.ovf   = dropped_ff;
      cmd_data.store = 1'b0;
      cmd_data.row   = row_id;
      if (accept) begin
         if (is_end) begin
            cmd_data.flush = in_group_ff;
            in_group_in    = 1'b0;
            cluster_in     = '0;
            function_in    = '0;
            last_pos_in    = '0;
            count_in       = '0;
            dropped_in     = 1'b0;
         end else if (new_group) begin
            cmd_data.flush = in_group_ff;
            cmd_data.store = 1'b1;
            in_group_in    = 1'b1;
            cluster_in     = cluster_id;
            function_in    = func_id;
            last_pos_in    = position;
            count_in       = CNT_W'(1);
            dropped_in     = 1'b0;
         end else if (spaced) begin
            last_pos_in = position;
            if (count_ff < CNT_W'(GROUP_DEPTH)) begin
               cmd_data.store = 1'b1;
               count_in       = count_ff + CNT_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
         end
      end
   end

   assign cmd_push = accept && (cmd_data.flush || cmd_data.store);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_group_ff <= 1'b0;
         cluster_ff  <= '0;
         function_ff <= '0;
         last_pos_ff <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         in_group_ff <= in_group_in;
         cluster_ff  <= cluster_in;
         function_ff <= function_in;
         last_pos_ff <= last_pos_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
      end
   end

endmodule

### sv/gsrf_queue.sv
// Short command queue between the front and the back of the row filter.
// Depth from gsrf_pkg::QUEUE_DEPTH. Uses gsrf_pkg.
module gsrf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gsrf_pkg::cmd_type  push_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output gsrf_pkg::cmd_type  pop_data
);
   import gsrf_pkg::*;

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### sv/gsrf_back.sv
// Back of the group spacing row filter: group row buffer and drain pipeline.
// Executes commands from gsrf_queue. Uses gsrf_pkg.
module gsrf_back #(
   parameter int GROUP_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  gsrf_pkg::cmd_type  q_data,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_kept_row,
   output logic               rsp_last_of_group,
   output logic               rsp_overflowed
);
   import gsrf_pkg::*;

   localparam int CNT_W = $clog2(GROUP_DEPTH + 1);
   localparam int IDX_W = $clog2(GROUP_DEPTH);

   back_state_type   state_ff, state_in;

   logic [31:0]      rows_ff [GROUP_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             pend_store_ff;
   logic [31:0]      pend_row_ff;
   logic             ovf_ff;

   // fetch stage (registered memory read) and output register
   logic             fv_ff, fv_in;
   logic [31:0]      rd_data_ff;
   logic             rd_last_ff;
   logic             ov_ff, ov_in;
   logic [31:0]      out_row_ff;
   logic             out_last_ff;
   logic             out_ovf_ff;

   logic             start;
   logic             move;
   logic             fetch_fire;
   logic             finish;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [31:0]      mem_wdata;
   logic [CNT_W-1:0] base;

   assign move       = fv_ff && (!ov_ff || rsp_pop);
   assign fetch_fire = (state_ff == BK_DRAIN) && (rd_idx_ff != count_ff) &&
                       (!fv_ff || move);
   assign finish     = (state_ff == BK_DRAIN) && move && rd_last_ff;
   assign base       = q_data.flush ? '0 : count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_data.flush && count_ff >= CNT_W'(2)) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (move && rd_last_ff) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      start     = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = base[IDX_W-1:0];
      mem_wdata = q_data.row;
      count_in  = count_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_data.flush && count_ff >= CNT_W'(2)) begin
                  start = 1'b1;
               end else if (q_data.store) begin
                  mem_we   = 1'b1;
                  count_in = base + CNT_W'(1);
               end else if (q_data.flush) begin
                  count_in = '0;
               end
            end
         end
         BK_DRAIN: begin
            // group done: open the next one with its first row, if one is pending
            if (move && rd_last_ff) begin
               mem_we    = pend_store_ff;
               mem_waddr = '0;
               mem_wdata = pend_row_ff;
               count_in  = pend_store_ff ? CNT_W'(1) : '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (start) begin
         rd_idx_in = '0;
      end else if (fetch_fire) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
      fv_in = fetch_fire || (fv_ff && !move);
      ov_in = move || (ov_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rows_ff[mem_waddr] <= mem_wdata;
      end
      if (fetch_fire) begin
         rd_data_ff <= rows_ff[rd_idx_ff[IDX_W-1:0]];
         rd_last_ff <= (rd_idx_ff + CNT_W'(1)) == count_ff;
      end
      if (start) begin
         pend_store_ff <= q_data.store;
         pend_row_ff   <= q_data.row;
         ovf_ff        <= q_data.ovf;
      end
      if (move) begin
         out_row_ff  <= rd_data_ff;
         out_last_ff <= rd_last_ff;
         out_ovf_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         count_ff  <= '0;
         rd_idx_ff <= '0;
         fv_ff     <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         fv_ff     <= fv_in;
         ov_ff     <= ov_in;
      end
   end

   assign rsp_empty         = !ov_ff;
   assign rsp_kept_row      = out_row_ff;
   assign rsp_last_of_group = out_last_ff;
   assign rsp_overflowed    = out_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(GROUP_DEPTH))
      else $error("group buffer count beyond depth");

   a_fetch_in_drain: assert property (@(posedge clock) disable iff (reset)
      fv_ff |-> state_ff == BK_DRAIN)
      else $error("fetched row outside a drain");

   a_idle_takes_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_IDLE && !q_empty) |-> q_pop)
      else $error("idle back end left a command waiting");

   a_drain_ends_reset: assert property (@(posedge clock) disable iff (reset)
      finish |=> count_ff <= CNT_W'(1))
      else $error("group buffer not restarted after drain");

endmodule

### sv/group_spacing_row_filter.sv
// Group spacing row filter. Records sorted by (cluster_id, func_id) and
// position are taken at one item per cycle when req_full is low; each spaced
// row of a group is written into a GROUP_DEPTH-entry buffer. When a group
// closes and holds two or more rows, the back end drains the buffer one row
// per cycle through a single read port while rsp_pop keeps up; meanwhile the
// four-entry command queue absorbs further items, then req_full rises until
// the drain ends. Uses gsrf_pkg, gsrf_front, gsrf_queue and gsrf_back.
module group_spacing_row_filter #(
   parameter int GROUP_DEPTH = gsrf_pkg::GROUP_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // item input
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_is_end,
   input  logic [31:0]                        req_cluster_id,
   input  logic [31:0]                        req_func_id,
   input  logic [31:0]                        req_position,
   input  logic [31:0]                        req_row_id,
   // result output
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [31:0]                        rsp_kept_row,
   output logic                               rsp_last_of_group,
   output logic                               rsp_overflowed,
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gsrf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import gsrf_pkg::*;

   logic [15:0] min_gap_ff;
   logic        csr_wr;
   logic        accept;
   logic        cmd_push;
   cmd_type     cmd_data;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   cmd_type     q_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_ADDR_MIN_GAP);
   assign csr_prdata = (csr_paddr == CSR_ADDR_MIN_GAP) ? {16'd0, min_gap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff <= MIN_GAP_RESET;
      end else if (csr_wr) begin
         min_gap_ff <= csr_pwdata[15:0];
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   gsrf_front #(
      .GROUP_DEPTH(GROUP_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .is_end      (req_is_end),
      .cluster_id  (req_cluster_id),
      .func_id     (req_func_id),
      .position    (req_position),
      .row_id      (req_row_id),
      .min_gap     (min_gap_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_data)
   );

   gsrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   gsrf_back #(
      .GROUP_DEPTH(GROUP_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kept_row      (rsp_kept_row),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_overflowed    (rsp_overflowed)
   );

endmodule

### verif/group_spacing_row_filter_test.sv
// Self-checking bench for group_spacing_row_filter: drives sorted records and end
// markers, predicts the flushed row groups in-line and checks every popped row.
// Depends on gsrf_pkg and the group_spacing_row_filter RTL.
module group_spacing_row_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import gsrf_pkg::*;

   localparam int ROW_DEPTH = GROUP_DEPTH_DEF;
   localparam int IDLE_SETTLE = ROW_DEPTH + 16;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_UNUSED = '1;

   typedef struct packed {
      logic [31:0] row;
      logic        last;
      logic        ovf;
   } row_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_is_end = 1'b0;
   logic [31:0] req_cluster_id = '0;
   logic [31:0] req_func_id = '0;
   logic [31:0] req_position = '0;
   logic [31:0] req_row_id = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_kept_row;
   logic        rsp_last_of_group;
   logic        rsp_overflowed;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   group_spacing_row_filter dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_is_end        (req_is_end),
      .req_cluster_id    (req_cluster_id),
      .req_func_id       (req_func_id),
      .req_position      (req_position),
      .req_row_id        (req_row_id),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kept_row      (rsp_kept_row),
      .rsp_last_of_group (rsp_last_of_group),
      .rsp_overflowed    (rsp_overflowed),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // predictor state
   logic [15:0] min_gap_cfg = MIN_GAP_RESET;
   logic        open_group = 1'b0;
   logic [31:0] open_cluster = '0;
   logic [31:0] open_function = '0;
   logic [31:0] last_kept_pos = '0;
   logic [31:0] kept_buf [ROW_DEPTH];
   int          kept_cnt = 0;
   logic        rows_dropped = 1'b0;

   row_result_type expected_rows [$];
   row_result_type head_row;

   int          errors = 0;
   int          records_sent = 0;
   int          ends_sent = 0;
   int          rows_checked = 0;
   int          groups_flushed = 0;
   int          groups_overflowed = 0;
   int          gap_settings = 0;
   int          send_quiet = 0;
   int          pop_quiet = 0;
   int unsigned cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: no progress after %0d cycles, %0d rows still outstanding",
                  cycle_count, expected_rows.size());
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void flag_error(string msg);
      errors++;
      if (errors <= 10)
         $display("ERROR: %s", msg);
   endfunction

   // wait drawn per item; now and then a run of items goes through without any
   function automatic int draw_wait(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0)
         quiet = $urandom_range(15, 40);
      return $urandom_range(0, 11);
   endfunction

   function automatic void flush_open_group();
      row_result_type r;
      if (open_group && kept_cnt >= 2) begin
         for (int i = 0; i < kept_cnt; i++) begin
            r.row = kept_buf[i];
            r.last = (i == kept_cnt - 1);
            r.ovf = rows_dropped;
            expected_rows.insert(expected_rows.size(), r);
         end
         groups_flushed++;
         if (rows_dropped)
            groups_overflowed++;
      end
   endfunction

   // a record past the spacing test moves the spacing anchor even when the
   // buffer is full and the row itself is lost
   function automatic void keep_record(logic [31:0] pos, logic [31:0] row);
      last_kept_pos = pos;
      if (kept_cnt < ROW_DEPTH) begin
         kept_buf[kept_cnt] = row;
         kept_cnt++;
      end else begin
         rows_dropped = 1'b1;
      end
   endfunction

   function automatic void filter_record(logic is_end, logic [31:0] cid, logic [31:0] fid,
                                         logic [31:0] pos, logic [31:0] row);
      logic [32:0] threshold;
      threshold = {1'b0, last_kept_pos} + {17'b0, min_gap_cfg};
      if (is_end) begin
         flush_open_group();
         open_group = 1'b0;
         open_cluster = '0;
         open_function = '0;
         last_kept_pos = '0;
         kept_cnt = 0;
         rows_dropped = 1'b0;
      end else if (!open_group || cid != open_cluster || fid != open_function) begin
         flush_open_group();
         open_group = 1'b1;
         open_cluster = cid;
         open_function = fid;
         kept_cnt = 0;
         rows_dropped = 1'b0;
         keep_record(pos, row);
      end else if ({1'b0, pos} >= threshold) begin
         keep_record(pos, row);
      end
   endfunction

   task automatic send_item(input logic is_end, input logic [31:0] cid,
                            input logic [31:0] fid, input logic [31:0] pos,
                            input logic [31:0] row);
      int w;
      w = draw_wait(send_quiet);
      if (w > 0) begin
         req_push <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_is_end <= is_end;
      req_cluster_id <= cid;
      req_func_id <= fid;
      req_position <= pos;
      req_row_id <= row;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      filter_record(is_end, cid, fid, pos, row);
      if (is_end)
         ends_sent++;
      else
         records_sent++;
   endtask

   task automatic stop_sending();
      req_push <= 1'b0;
   endtask

   // drained means no row outstanding plus time for items that emit nothing
   task automatic wait_idle();
      for (int w = 0; w < 20000 && expected_rows.size() != 0; w++)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == CSR_ADDR_MIN_GAP)
         min_gap_cfg = data[15:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] want);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         flag_error($sformatf("register read at %0d: expected %h, got %h",
                              addr, want, csr_prdata));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_min_gap(input logic [15:0] gap);
      stop_sending();
      wait_idle();
      csr_write(CSR_ADDR_MIN_GAP, {16'h0, gap});
      csr_read(CSR_ADDR_MIN_GAP, {16'h0, gap});
      gap_settings++;
   endtask

   function automatic logic [31:0] next_step(logic [15:0] gap);
      int gi;
      gi = int'(gap);
      case ($urandom_range(0, 3))
         0: return gi;
         1: return (gi == 0) ? 0 : gi - 1;
         2: return $urandom_range(0, 2 * gi + 1);
         default: return $urandom_range(gi, gi + 3);
      endcase
   endfunction

   // id changes on one or both fields, a stale row, end markers with and
   // without an open group, and the 33-bit no-wrap compare at the top of range
   task automatic test_directed_groups();
      csr_read(CSR_ADDR_MIN_GAP, {16'h0, MIN_GAP_RESET});
      send_item(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
      send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'h0000_0001);
      send_item(1'b0, 32'h0, 32'h0, 32'h1, 32'h0);
      send_item(1'b0, '1, '1, '1, 32'h1234_5678);
      send_item(1'b0, '1, '1, '1, 32'h9ABC_DEF0);
      send_item(1'b0, '1, 32'h0, 32'd5, 32'd1);
      send_item(1'b0, '1, 32'h0, 32'd7, 32'd2);
      send_item(1'b0, '1, 32'h0, 32'd6, 32'd3);
      send_item(1'b0, '1, 32'h0, 32'd8, 32'd4);
      send_item(1'b0, 32'h0, 32'h0, 32'h8000_0000, 32'd5);
      send_item(1'b0, 32'h0, 32'h0, 32'h8000_0001, 32'd6);
      send_item(1'b1, '1, '1, '1, '1);
      send_item(1'b0, 32'h0, 32'h0, 32'h0, 32'd7);
      send_item(1'b0, 32'h0, 32'h0, 32'h1, 32'd8);
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_gap_extremes();
      set_min_gap(16'h0000);
      send_item(1'b0, 32'd3, 32'd4, 32'd7, 32'd10);
      send_item(1'b0, 32'd3, 32'd4, 32'd7, 32'd11);
      send_item(1'b0, 32'd3, 32'd4, 32'd6, 32'd12);
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
      set_min_gap(16'hFFFF);
      send_item(1'b0, 32'd5, 32'd6, 32'hFFFF_0000, 32'd20);
      send_item(1'b0, 32'd5, 32'd6, 32'hFFFF_FFFE, 32'd21);
      send_item(1'b0, 32'd5, 32'd6, 32'hFFFF_FFFF, 32'd22);
      send_item(1'b0, 32'd5, 32'd7, 32'hFFFF_0001, 32'd23);
      send_item(1'b0, 32'd5, 32'd7, 32'hFFFF_FFFF, 32'd24);
      send_item(1'b0, 32'd5, 32'd7, 32'h0, 32'd25);
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
      // a write outside the register map leaves min_gap alone
      stop_sending();
      wait_idle();
      csr_write(CSR_ADDR_UNUSED, 32'h0000_0002);
      csr_read(CSR_ADDR_MIN_GAP, 32'h0000_FFFF);
   endtask

   task automatic test_buffer_overflow();
      logic [31:0] base;
      set_min_gap(16'd1);
      // exactly full, then a record that fails spacing: no drop
      base = $urandom_range(0, 1000);
      for (int i = 0; i < ROW_DEPTH; i++)
         send_item(1'b0, 32'hA0, 32'h1, base + i, $urandom());
      send_item(1'b0, 32'hA0, 32'h1, base + ROW_DEPTH - 1, $urandom());
      base = $urandom_range(0, 32'h7FFF_0000);
      for (int i = 0; i < ROW_DEPTH + 6; i++)
         send_item(1'b0, 32'hA0, 32'h2, base + 2 * i, $urandom());
      send_item(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
      // the drop flag must not carry into the next group
      send_item(1'b0, 32'hA0, 32'h3, 32'd10, $urandom());
      send_item(1'b0, 32'hA0, 32'h3, 32'd11, $urandom());
      send_item(1'b1, 32'h0, 32'h0, 32'h0, 32'h0);
   endtask

   task automatic test_random_groups(input int n_items, input logic [15:0] gap);
      logic [31:0] cluster_pool [4];
      logic [31:0] func_pool [4];
      logic [31:0] cid;
      logic [31:0] fid;
      logic [31:0] pos;
      int sent;
      int len;
      int pick;
      set_min_gap(gap);
      for (int i = 0; i < 4; i++) begin
         cluster_pool[i] = $urandom();
         func_pool[i] = $urandom();
      end
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            send_item(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
            sent++;
         end else if (pick == 1) begin
            send_item(1'b0, $urandom(), $urandom(), $urandom(), $urandom());
            sent++;
         end else begin
            cid = cluster_pool[$urandom_range(0, 3)];
            fid = func_pool[$urandom_range(0, 3)];
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            case ($urandom_range(0, 2))
               0: pos = $urandom();
               1: pos = $urandom_range(0, 100);
               default: pos = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(gap) + 2);
            endcase
            for (int k = 0; k < len && sent < n_items; k++) begin
               send_item(1'b0, cid, fid, pos, $urandom());
               sent++;
               pos = pos + next_step(gap);
            end
         end
      end
   endtask

   // result side: pop with random stalls
   initial begin
      int w;
      forever begin
         w = draw_wait(pop_quiet);
         if (w > 0) begin
            rsp_pop <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty || reset);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rows.size() == 0) begin
            flag_error($sformatf("row %h last %b ovf %b popped with none outstanding",
                                 rsp_kept_row, rsp_last_of_group, rsp_overflowed));
         end else begin
            head_row = expected_rows.pop_front();
            rows_checked++;
            if (rsp_kept_row !== head_row.row || rsp_last_of_group !== head_row.last ||
                rsp_overflowed !== head_row.ovf)
               flag_error($sformatf("expected row %h last %b ovf %b, got row %h last %b ovf %b",
                                    head_row.row, head_row.last, head_row.ovf,
                                    rsp_kept_row, rsp_last_of_group, rsp_overflowed));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_groups();
      test_gap_extremes();
      test_buffer_overflow();
      test_random_groups(30, 16'd1);
      test_random_groups(25, 16'd0);
      test_random_groups(25, 16'd2);
      test_random_groups(25, 16'hFFFF);
      test_random_groups(20, 16'($urandom_range(3, 40)));
      test_random_groups(18, 16'($urandom_range(0, 65535)));
      stop_sending();
      wait_idle();
      if (expected_rows.size() != 0)
         flag_error($sformatf("%0d expected rows never arrived", expected_rows.size()));
      $display("Sent %0d records and %0d end markers under %0d min_gap settings.",
               records_sent, ends_sent, gap_settings);
      $display("Checked %0d rows from %0d flushed groups, %0d of them with dropped rows.",
               rows_checked, groups_flushed, groups_overflowed);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
